// File: rtl/channel_filter_bw_encoder_unit_assert.svh
// Assertion macros used by the checker of the channel filter bandwidth encoder.
`ifndef CHANNEL_FILTER_BW_ENCODER_UNIT_ASSERT_SVH
`define CHANNEL_FILTER_BW_ENCODER_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the trigger.
`define CFBW_ASSERT_NOW(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> cons) else $error(msg);

// The consequent holds in the cycle after the trigger.
`define CFBW_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> cons) else $error(msg);

`endif

// File: rtl/cfbw_pkg.sv
// Shared constants, types and table functions of the channel filter bandwidth encoder.
package cfbw_pkg;

  localparam int unsigned TabLen      = 90;
  localparam int unsigned IdxW        = 7;
  localparam int unsigned BwW         = 21;
  localparam int unsigned XtalW       = 26;
  localparam int unsigned EntryW      = 13;
  localparam int unsigned FactorW     = 20;
  localparam int unsigned ProdW       = EntryW + FactorW;
  localparam int unsigned FieldW      = 4;
  localparam int unsigned StepsPerExp = 9;
  localparam int unsigned NumExp      = TabLen / StepsPerExp;

  // Division by 100: drop two bits, then multiply by the reciprocal of 25.
  // The reciprocal is exact for every 24-bit dividend.
  localparam int unsigned      FactorPreSh  = 2;
  localparam int unsigned      FactorShift  = 29;
  localparam int unsigned      FactorRecipW = 25;
  localparam logic [FactorRecipW-1:0] FactorRecip = 25'd21474837;

  // Division by 2600: drop three bits, then multiply by the reciprocal of 325.
  // The reciprocal is exact for every 30-bit dividend.
  localparam int unsigned      ScalePreSh  = 3;
  localparam int unsigned      ScaleShift  = 39;
  localparam int unsigned      ScaleRecipW = 31;
  localparam logic [ScaleRecipW-1:0] ScaleRecip = 31'd1691556351;

  localparam logic [XtalW-1:0] XtalReset = XtalW'(26000000);

  // Configuration register indexes.
  localparam logic CfgXtal  = 1'b0;
  localparam logic CfgDivOn = 1'b1;

  typedef logic [BwW-1:0]               bw_t;
  typedef logic [IdxW-1:0]              idx_t;
  typedef logic [TabLen-1:0][BwW-1:0]   scaled_tab_t;

  // Bandwidth table in units of 0.1 kHz for a 26 MHz crystal, descending.
  localparam logic [EntryW-1:0] BwTable [TabLen] = '{
    13'd8001, 13'd7951, 13'd7684, 13'd7368, 13'd7051, 13'd6709, 13'd6423, 13'd5867, 13'd5414,
    13'd4509, 13'd4259, 13'd4032, 13'd3808, 13'd3621, 13'd3417, 13'd3254, 13'd2945, 13'd2703,
    13'd2247, 13'd2124, 13'd2011, 13'd1900, 13'd1807, 13'd1706, 13'd1624, 13'd1471, 13'd1350,
    13'd1123, 13'd1062, 13'd1005, 13'd950,  13'd903,  13'd853,  13'd812,  13'd735,  13'd675,
    13'd561,  13'd530,  13'd502,  13'd474,  13'd451,  13'd426,  13'd406,  13'd367,  13'd337,
    13'd280,  13'd265,  13'd251,  13'd237,  13'd226,  13'd213,  13'd203,  13'd184,  13'd169,
    13'd140,  13'd133,  13'd126,  13'd119,  13'd113,  13'd106,  13'd101,  13'd92,   13'd84,
    13'd70,   13'd66,   13'd63,   13'd59,   13'd56,   13'd53,   13'd51,   13'd46,   13'd42,
    13'd35,   13'd33,   13'd31,   13'd30,   13'd28,   13'd27,   13'd25,   13'd23,   13'd21,
    13'd18,   13'd17,   13'd16,   13'd15,   13'd14,   13'd13,   13'd13,   13'd12,   13'd11
  };

  // Table entry at an index; indexes past the end read as zero.
  function automatic logic [EntryW-1:0] bw_entry(idx_t idx);
    logic [EntryW-1:0] val;
    val = '0;
    if (32'(idx) < TabLen) begin
      val = BwTable[idx];
    end
    return val;
  endfunction

  // Exponent field: the index divided by the steps per exponent, for indexes inside the table.
  function automatic logic [FieldW-1:0] idx_exp(idx_t idx);
    logic [FieldW-1:0] e;
    e = '0;
    for (int unsigned k = 1; k < NumExp; k++) begin
      if (32'(idx) >= k * StepsPerExp) begin
        e = FieldW'(k);
      end
    end
    return e;
  endfunction

  // Mantissa field: the index modulo the steps per exponent, for indexes inside the table.
  function automatic logic [FieldW-1:0] idx_mant(idx_t idx);
    logic [IdxW-1:0] base;
    base = IdxW'(32'(idx_exp(idx)) * StepsPerExp);
    return FieldW'(idx - base);
  endfunction

endpackage

// File: rtl/cfbw_scale.sv
// Configuration registers and the sequencer that builds the scaled bandwidth table.
module cfbw_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [cfbw_pkg::XtalW-1:0] cfg_data_i,
  output logic                      busy_o,
  output cfbw_pkg::scaled_tab_t     scaled_o
);

  localparam int unsigned FacInW  = cfbw_pkg::XtalW - cfbw_pkg::FactorPreSh;
  localparam int unsigned FacMulW = FacInW + cfbw_pkg::FactorRecipW;
  localparam int unsigned ScInW   = cfbw_pkg::ProdW - cfbw_pkg::ScalePreSh;
  localparam int unsigned ScMulW  = ScInW + cfbw_pkg::ScaleRecipW;
  localparam cfbw_pkg::idx_t  LastIdx = cfbw_pkg::IdxW'(cfbw_pkg::TabLen - 1);

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_FACTOR = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } scale_state_e;

  scale_state_e                   state_q, state_d;
  cfbw_pkg::idx_t                 idx_q, idx_d;
  logic [cfbw_pkg::XtalW-1:0]     xtal_q, xtal_d;
  logic                           div_on_q, div_on_d;
  logic [cfbw_pkg::ProdW-1:0]     prod_q, prod_d;
  logic [cfbw_pkg::FactorW-1:0]   factor_q, factor_d;
  cfbw_pkg::scaled_tab_t          scaled_q, scaled_d;

  logic [cfbw_pkg::XtalW-1:0]     xtal_eff;
  logic [FacMulW-1:0]             fac_mul;
  logic [cfbw_pkg::FactorW-1:0]   factor_nx;
  logic [cfbw_pkg::ProdW-1:0]     prod;
  logic [ScMulW-1:0]              sc_mul;
  cfbw_pkg::bw_t                  scaled_nx;

  // Scaling factor: the effective crystal frequency divided by 100.
  assign xtal_eff  = div_on_q ? (xtal_q >> 1) : xtal_q;
  assign fac_mul   = FacMulW'(xtal_eff[cfbw_pkg::XtalW-1:cfbw_pkg::FactorPreSh]) *
                     FacMulW'(cfbw_pkg::FactorRecip);
  assign factor_nx = fac_mul[cfbw_pkg::FactorShift +: cfbw_pkg::FactorW];

  // Product of the current table entry and the factor.
  assign prod = cfbw_pkg::ProdW'(idx_q >= cfbw_pkg::IdxW'(cfbw_pkg::TabLen) ? '0 :
                {{cfbw_pkg::FactorW{1'b0}}, cfbw_pkg::bw_entry(idx_q)} *
                {{cfbw_pkg::EntryW{1'b0}}, factor_q});

  // Registered product divided by 2600.
  assign sc_mul    = ScMulW'(prod_q[cfbw_pkg::ProdW-1:cfbw_pkg::ScalePreSh]) *
                     ScMulW'(cfbw_pkg::ScaleRecip);
  assign scaled_nx = sc_mul[cfbw_pkg::ScaleShift +: cfbw_pkg::BwW];

  // Sequencer: load, then the factor, then a multiply state and a scaling state for each entry.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    xtal_d   = xtal_q;
    div_on_d = div_on_q;
    prod_d   = prod_q;
    factor_d = factor_q;
    scaled_d = scaled_q;
    unique case (state_q)
      ST_LOAD: begin
        state_d = ST_FACTOR;
      end
      ST_FACTOR: begin
        factor_d = factor_nx;
        idx_d    = '0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = prod;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        scaled_d[idx_q] = scaled_nx;
        if (idx_q == LastIdx) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        state_d = ST_DONE;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // A register write restarts the table build.
    if (cfg_we_i) begin
      if (cfg_index_i == cfbw_pkg::CfgXtal) begin
        xtal_d = cfg_data_i;
      end else begin
        div_on_d = cfg_data_i[0];
      end
      state_d = ST_LOAD;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      idx_q    <= '0;
      xtal_q   <= cfbw_pkg::XtalReset;
      div_on_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      xtal_q   <= xtal_d;
      div_on_q <= div_on_d;
    end
  end

  // Datapath registers and the scaled table.
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    factor_q <= factor_d;
    scaled_q <= scaled_d;
  end

  assign busy_o   = (state_q != ST_DONE);
  assign scaled_o = scaled_q;

endmodule

// File: rtl/cfbw_search.sv
// Five-stage pipeline that finds the nearest scaled table entry for a request.
module cfbw_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  cfbw_pkg::bw_t               req_i,
  input  cfbw_pkg::scaled_tab_t       scaled_i,
  output logic                        out_valid_o,
  output logic [cfbw_pkg::FieldW-1:0] exp_o,
  output logic [cfbw_pkg::FieldW-1:0] mant_o,
  output cfbw_pkg::bw_t               bw_o
);

  localparam int unsigned N = cfbw_pkg::TabLen;

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  cfbw_pkg::bw_t          req1_q, req2_q, req3_q;
  logic [N-1:0]           lt2_q, lt_d;
  logic [N:0]             edge_oh;
  cfbw_pkg::idx_t         first_d, first3_q;
  cfbw_pkg::bw_t          a_d, b_d, c_d, a3_q, b3_q, c3_q;
  cfbw_pkg::idx_t         ch_d, ch4_q;
  cfbw_pkg::bw_t          val_d, val4_q;
  cfbw_pkg::bw_t          da, db, dc, best;
  logic [cfbw_pkg::FieldW-1:0] exp5_q, mant5_q;
  cfbw_pkg::bw_t          bw5_q;

  // Stage 2: compare the request against every scaled entry.
  always_comb begin
    for (int unsigned i = 0; i < N; i++) begin
      lt_d[i] = (req1_q < scaled_i[i]);
    end
  end

  // Stage 3: locate the first entry not above the request and its neighbors.
  always_comb begin
    edge_oh[0] = !lt2_q[0];
    for (int unsigned i = 1; i < N; i++) begin
      edge_oh[i] = lt2_q[i-1] & !lt2_q[i];
    end
    edge_oh[N] = lt2_q[N-1];
    first_d = '0;
    a_d = '0;
    b_d = '0;
    c_d = '0;
    for (int unsigned i = 0; i <= N; i++) begin
      first_d = first_d | (edge_oh[i] ? cfbw_pkg::IdxW'(i) : '0);
    end
    for (int unsigned i = 0; i < N; i++) begin
      a_d = a_d | (edge_oh[i+1] ? scaled_i[i] : '0);
      b_d = b_d | (edge_oh[i] ? scaled_i[i] : '0);
    end
    for (int unsigned i = 1; i < N; i++) begin
      c_d = c_d | (edge_oh[i-1] ? scaled_i[i] : '0);
    end
  end

  // Stage 4: closest of the candidates, lower index first on a tie.
  always_comb begin
    da = (req3_q >= a3_q) ? req3_q - a3_q : a3_q - req3_q;
    db = (req3_q >= b3_q) ? req3_q - b3_q : b3_q - req3_q;
    dc = (req3_q >= c3_q) ? req3_q - c3_q : c3_q - req3_q;
    best = da;
    if (first3_q == '0) begin
      ch_d  = '0;
      val_d = b3_q;
    end else begin
      ch_d  = first3_q - 1'b1;
      val_d = a3_q;
      if (first3_q < cfbw_pkg::IdxW'(N) && db < best) begin
        best  = db;
        ch_d  = first3_q;
        val_d = b3_q;
      end
      if (first3_q < cfbw_pkg::IdxW'(N - 1) && dc < best) begin
        ch_d  = first3_q + 1'b1;
        val_d = c3_q;
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload of every stage.
  always_ff @(posedge clk_i) begin
    req1_q   <= req_i;
    req2_q   <= req1_q;
    lt2_q    <= lt_d;
    req3_q   <= req2_q;
    first3_q <= first_d;
    a3_q     <= a_d;
    b3_q     <= b_d;
    c3_q     <= c_d;
    ch4_q    <= ch_d;
    val4_q   <= val_d;
    exp5_q   <= cfbw_pkg::idx_exp(ch4_q);
    mant5_q  <= cfbw_pkg::idx_mant(ch4_q);
    bw5_q    <= val4_q;
  end

  assign out_valid_o = v5_q;
  assign exp_o       = exp5_q;
  assign mant_o      = mant5_q;
  assign bw_o        = bw5_q;

endmodule

// File: rtl/channel_filter_bw_encoder_unit.sv
// Top level of the channel filter bandwidth encoder.
// A result is strobed for every request taken while busy is low, in request order.
// Throughput: one request per cycle while busy is low; results cannot be held off.
// After reset or any register write the scaled table is rebuilt one entry at a time,
// with busy high; register writes are always taken.
module channel_filter_bw_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [cfbw_pkg::BwW-1:0]    bandwidth_hz_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [cfbw_pkg::XtalW-1:0]  cfg_data_i,
  output logic                        result_valid_o,
  output logic [cfbw_pkg::FieldW-1:0] bw_exponent_o,
  output logic [cfbw_pkg::FieldW-1:0] bw_mantissa_o,
  output logic [cfbw_pkg::BwW-1:0]    achieved_bw_hz_o
);

  cfbw_pkg::scaled_tab_t scaled;
  logic                  cfg_we;

  // Configuration beats are always accepted.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  cfbw_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .scaled_o   (scaled)
  );

  cfbw_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start & !busy),
    .req_i      (bandwidth_hz_i),
    .scaled_i   (scaled),
    .out_valid_o(result_valid_o),
    .exp_o      (bw_exponent_o),
    .mant_o     (bw_mantissa_o),
    .bw_o       (achieved_bw_hz_o)
  );

endmodule

// File: rtl/cfbw_checker.sv
// Port-level checker of the channel filter bandwidth encoder and its bind.
`include "channel_filter_bw_encoder_unit_assert.svh"

module cfbw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic                        result_valid_o,
  input logic [cfbw_pkg::FieldW-1:0] bw_exponent_o,
  input logic [cfbw_pkg::FieldW-1:0] bw_mantissa_o
);

  // Every accepted request gives a result strobe.
  `CFBW_ASSERT_NOW(a_latency, clk_i, rst_ni, start && !busy, ##5 result_valid_o, "result missing after request")
  // No result appears without an earlier accepted request.
  `CFBW_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, result_valid_o, $past(start && !busy, 5), "result without request")
  // A register write restarts the table build.
  `CFBW_ASSERT_NEXT(a_cfg_busy, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, busy, "busy not raised after write")
  // The fields stay in the table's range.
  `CFBW_ASSERT_NOW(a_range, clk_i, rst_ni, result_valid_o, (bw_exponent_o <= 4'd9 && bw_mantissa_o <= 4'd8), "field out of range")

endmodule

bind channel_filter_bw_encoder_unit cfbw_checker u_cfbw_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the channel filter bandwidth encoder unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 20;

  typedef struct packed {
    logic [cfbw_pkg::FieldW-1:0] exponent;
    logic [cfbw_pkg::FieldW-1:0] mantissa;
    cfbw_pkg::bw_t               achieved;
  } bw_code_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  cfbw_pkg::bw_t    bandwidth_hz_i = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = cfbw_pkg::CfgXtal;
  logic [cfbw_pkg::XtalW-1:0] cfg_data_i = '0;
  logic             result_valid_o;
  logic [cfbw_pkg::FieldW-1:0] bw_exponent_o;
  logic [cfbw_pkg::FieldW-1:0] bw_mantissa_o;
  cfbw_pkg::bw_t    achieved_bw_hz_o;

  // Local copy of the configuration registers.
  logic [cfbw_pkg::XtalW-1:0] xtal_hz = cfbw_pkg::XtalReset;
  logic             half_xtal = 1'b0;

  cfbw_pkg::bw_t request_queue[$];
  bw_code_t    expected_codes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        hold_requests = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  channel_filter_bw_encoder_unit DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Table entry scaled to the current crystal setting, in Hz.
  function automatic cfbw_pkg::bw_t entry_hz(int unsigned idx);
    longint unsigned factor;
    factor = (half_xtal ? (longint'(xtal_hz) >> 1) : longint'(xtal_hz)) / 100;
    return cfbw_pkg::bw_t'((longint'(cfbw_pkg::BwTable[idx]) * factor) / 2600);
  endfunction

  // Nearest table entry for a requested bandwidth; ties go to the lower index.
  function automatic bw_code_t nearest_code(cfbw_pkg::bw_t req);
    int unsigned first;
    int unsigned chosen;
    longint unsigned best;
    longint unsigned delta;
    bw_code_t code;
    first = 0;
    while (first < cfbw_pkg::TabLen && req < entry_hz(first)) first++;
    chosen = 0;
    if (first != 0) begin
      chosen = cfbw_pkg::TabLen - 1;
      best = '1;
      for (int unsigned k = first - 1; k <= first + 1; k++) begin
        if (k < cfbw_pkg::TabLen) begin
          delta = (req >= entry_hz(k)) ? req - entry_hz(k) : entry_hz(k) - req;
          if (k == first - 1 || delta < best) begin
            best = delta;
            chosen = k;
          end
        end
      end
    end
    code.exponent = cfbw_pkg::FieldW'(chosen / cfbw_pkg::StepsPerExp);
    code.mantissa = cfbw_pkg::FieldW'(chosen % cfbw_pkg::StepsPerExp);
    code.achieved = entry_hz(chosen);
    return code;
  endfunction

  // Driver: sends requests in bursts with random gaps in between.
  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_codes.push_back(nearest_code(bandwidth_hz_i));
    end
    if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (request_queue.size() > 0 && !hold_requests) begin
        start <= 1'b1;
        bandwidth_hz_i <= request_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    bw_code_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result exp=%0d mant=%0d bw=%0d", $time,
                 bw_exponent_o, bw_mantissa_o, achieved_bw_hz_o);
        error_count++;
      end else begin
        want = expected_codes.pop_front();
        if (bw_exponent_o !== want.exponent) begin
          $display("%0t: exponent expected %0d actual %0d", $time, want.exponent,
                   bw_exponent_o);
          error_count++;
        end
        if (bw_mantissa_o !== want.mantissa) begin
          $display("%0t: mantissa expected %0d actual %0d", $time, want.mantissa,
                   bw_mantissa_o);
          error_count++;
        end
        if (achieved_bw_hz_o !== want.achieved) begin
          $display("%0t: achieved bandwidth expected %0d actual %0d", $time,
                   want.achieved, achieved_bw_hz_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Waits until every queued request has been taken and answered.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_queue.size() > 0 || start || expected_codes.size() > 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Writes one configuration register and updates the local copy.
  task automatic write_reg(logic idx, logic [cfbw_pkg::XtalW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cfbw_pkg::CfgXtal) begin
      xtal_hz = value;
    end else begin
      half_xtal = value[0];
    end
    @(posedge clk_i);
  endtask

  // Queues random requests, most of them close to a scaled table entry.
  task automatic queue_random(int unsigned count);
    int unsigned idx;
    int signed offset;
    longint signed val;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, cfbw_pkg::TabLen - 1);
        offset = $urandom_range(0, 400) - 200;
        val = longint'(entry_hz(idx)) + offset;
        if (val < 0) val = 0;
        if (val > 2097151) val = 2097151;
        request_queue.push_back(cfbw_pkg::bw_t'(val));
      end else begin
        request_queue.push_back(cfbw_pkg::bw_t'($urandom));
      end
    end
  endtask

  // Queues the edges of the table, midpoints between neighbors and values just above an entry.
  task automatic queue_directed();
    request_queue.push_back('0);
    request_queue.push_back('1);
    request_queue.push_back(entry_hz(0));
    request_queue.push_back(cfbw_pkg::bw_t'(entry_hz(0) - 1));
    request_queue.push_back(cfbw_pkg::bw_t'(entry_hz(0) + 1));
    request_queue.push_back(entry_hz(cfbw_pkg::TabLen - 1));
    request_queue.push_back(cfbw_pkg::bw_t'(entry_hz(cfbw_pkg::TabLen - 1) - 1));
    request_queue.push_back(entry_hz(cfbw_pkg::TabLen - 3));
    for (int unsigned k = 0; k + 1 < cfbw_pkg::TabLen; k += 11) begin
      request_queue.push_back(
          cfbw_pkg::bw_t'((longint'(entry_hz(k)) + entry_hz(k + 1)) / 2));
      request_queue.push_back(cfbw_pkg::bw_t'(entry_hz(k + 1) + 1));
    end
  endtask

  // Stimulus phases across several crystal and divider settings.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    queue_random(40);
    // Pause the sender mid-stream until every expected result has come.
    wait (request_queue.size() < 20);
    hold_requests = 1'b1;
    do @(posedge clk_i);
    while (start || expected_codes.size() > 0);
    hold_requests = 1'b0;
    wait_idle();
    queue_random(60);
    wait_idle();
    write_reg(cfbw_pkg::CfgXtal, cfbw_pkg::XtalW'(52000000));
    queue_directed();
    queue_random(90);
    wait_idle();
    write_reg(cfbw_pkg::CfgDivOn, 1'b1);
    write_reg(cfbw_pkg::CfgXtal, cfbw_pkg::XtalW'(24000000));
    queue_directed();
    queue_random(90);
    wait_idle();
    write_reg(cfbw_pkg::CfgXtal, '1);
    write_reg(cfbw_pkg::CfgDivOn, 1'b0);
    queue_directed();
    queue_random(90);
    wait_idle();
    // A tiny crystal scales most entries to zero.
    write_reg(cfbw_pkg::CfgXtal, cfbw_pkg::XtalW'(150));
    queue_directed();
    queue_random(20);
    wait_idle();
    write_reg(cfbw_pkg::CfgXtal, cfbw_pkg::XtalW'($urandom_range(24000000, 52000000)));
    write_reg(cfbw_pkg::CfgDivOn, 1'($urandom));
    queue_directed();
    queue_random(90);
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
